// ----- sv/partial_block_first_fit_allocator_defines.svh -----
// Assertion macros shared by the partial block first-fit allocator RTL.
`ifndef PARTIAL_BLOCK_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define PARTIAL_BLOCK_FIRST_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define PFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PFA_ASSERT_IMP(lbl, ante, cons)
`define PFA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- sv/pfa_pkg.sv -----
// Shared types and constants of the partial block first-fit allocator.
package pfa_pkg;

    localparam int MAX_PARTIAL_BLOCKS = 16;
    localparam int ALIGN_BYTES        = 8;
    localparam int IDX_W = (MAX_PARTIAL_BLOCKS > 1) ? $clog2(MAX_PARTIAL_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_PARTIAL_BLOCKS + 1);

    localparam int ID_W   = 32;
    localparam int SEG_W  = 32;
    localparam int BS_W   = 25;
    localparam int THR_W  = 17;
    localparam int OFF_W  = 24;
    localparam int AOFF_W = BS_W + 1;
    localparam int SUM_W  = SEG_W + 1;

    typedef enum logic [1:0] {
        ACT_ALLOC    = 2'd0,
        ACT_REGISTER = 2'd1,
        ACT_FLUSH    = 2'd2,
        ACT_UNUSED   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNTRACKED = 2'd1,
        ST_DROPPED   = 2'd2,
        ST_RESERVED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0] blk_id;
        logic [BS_W-1:0] used;
        logic [BS_W-1:0] capacity;
    } t_entry;

    typedef struct packed {
        logic [AOFF_W-1:0] offset;
        logic [SUM_W-1:0]  sum;
        logic              fits;
    } t_fit;

endpackage

// ----- sv/pfa_table.sv -----
// Partial block table memory with one write port and one registered read port.
module pfa_table (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [pfa_pkg::IDX_W-1:0] i_wr_addr,
    input  pfa_pkg::t_entry         i_wr_data,
    input  logic [pfa_pkg::IDX_W-1:0] i_rd_addr,
    output pfa_pkg::t_entry         o_rd_data
);
    import pfa_pkg::*;

    t_entry r_mem [MAX_PARTIAL_BLOCKS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/pfa_fit.sv -----
// Fit unit: aligns a block's used count and checks a segment against its capacity.
module pfa_fit (
    input  logic [pfa_pkg::BS_W-1:0]  i_used,
    input  logic [pfa_pkg::BS_W-1:0]  i_capacity,
    input  logic [pfa_pkg::SEG_W-1:0] i_seg,
    output pfa_pkg::t_fit             o_fit
);
    import pfa_pkg::*;

    localparam logic [AOFF_W-1:0] ALIGN_M1 = AOFF_W'(ALIGN_BYTES - 1);

    logic [AOFF_W-1:0] w_off;
    logic [SUM_W-1:0]  w_sum;

    always_comb begin
        w_off = (AOFF_W'(i_used) + ALIGN_M1) & ~ALIGN_M1;
        w_sum = SUM_W'(w_off) + SUM_W'(i_seg);
        o_fit.offset = w_off;
        o_fit.sum    = w_sum;
        o_fit.fits   = (w_sum <= SUM_W'(i_capacity));
    end

endmodule

// ----- sv/partial_block_first_fit_allocator.sv -----
// Top level of the partial block first-fit allocator with its sequencer and APB registers.
// One request is handled at a time. An allocate request passes through the multiply and
// check states; it then goes straight to the output state when it gets a dedicated block,
// and otherwise first scans the table entries in order until one fits, opening a fresh
// block when none does (untracked when all sixteen entries are in use); the first-fit scan
// reads the table memory one entry per cycle through its single read port and one shared
// fit unit. Register requests pass through the register state first, flush and unused
// requests go straight to the output state. The input is ready again in the cycle after
// the result is loaded. The result sits in an output register, so the next request is taken
// while a finished result still waits; a later result is held in the sequencer until the output register is free.
`include "partial_block_first_fit_allocator_defines.svh"

module partial_block_first_fit_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // APB configuration port
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready,
    // Request stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,  // seg_bytes[31:0], given_block_id[63:32], fill_bytes[88:64]
    input  logic [1:0]   i_s_tuser,  // action[1:0]
    // Result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [87:0]  o_m_tdata,  // result_block_id[31:0], result_offset[55:32], result_size[87:56]
    output logic [2:0]   o_m_tuser   // used_fresh_id[0], status[2:1]
);
    import pfa_pkg::*;

    localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [2:0] REG_THRESHOLD  = 3'd4;
    localparam int PROD_W = BS_W + THR_W;
    localparam logic [THR_W-1:0] Q_ONE = THR_W'(65536);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTIAL_BLOCKS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_NEW  = 7'b0010000,
        S_REG  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [BS_W-1:0]   r_block_size;
    logic [THR_W-1:0]  r_thr_q16;
    logic [SEG_W-1:0]  r_seg, n_seg;
    logic [ID_W-1:0]   r_bid, n_bid;
    logic [BS_W-1:0]   r_used, n_used;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic [OFF_W-1:0]  r_res_off, n_res_off;
    logic [SEG_W-1:0]  r_res_size, n_res_size;
    logic              r_res_fresh, n_res_fresh;
    t_status           r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [87:0]       r_out_data, n_out_data;
    logic [2:0]        r_out_user, n_out_user;

    logic              w_s_accept;
    logic              w_cfg_wr;
    logic [THR_W-1:0]  w_q;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_entry            w_wr_data;
    logic [IDX_W-1:0]  w_rd_addr;
    t_entry            w_rd_data;
    t_fit              w_fit;

    pfa_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    pfa_fit u_fit (
        .i_used     (w_rd_data.used),
        .i_capacity (w_rd_data.capacity),
        .i_seg      (r_seg),
        .o_fit      (w_fit)
    );

    assign w_s_accept = i_s_tvalid && o_s_tready;
    assign w_cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign o_pready   = 1'b1;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign w_q        = (r_thr_q16 > Q_ONE) ? Q_ONE : r_thr_q16;

    always_comb begin
        case (i_paddr)
            REG_BLOCK_SIZE: o_prdata = 32'(r_block_size);
            REG_THRESHOLD:  o_prdata = 32'(r_thr_q16);
            default:        o_prdata = '0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_seg        = r_seg;
        n_bid        = r_bid;
        n_used       = r_used;
        n_prod       = r_prod;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_id     = r_res_id;
        n_res_off    = r_res_off;
        n_res_size   = r_res_size;
        n_res_fresh  = r_res_fresh;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_count[IDX_W-1:0];
        w_wr_data    = '{blk_id: r_bid, used: r_seg[BS_W-1:0], capacity: r_block_size};
        w_rd_addr    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_s_accept) begin
                    n_seg        = i_s_tdata[31:0];
                    n_bid        = i_s_tdata[63:32];
                    n_used       = i_s_tdata[88:64];
                    n_res_id     = '0;
                    n_res_off    = '0;
                    n_res_size   = '0;
                    n_res_fresh  = 1'b0;
                    n_res_status = ST_OK;
                    case (t_action'(i_s_tuser))
                        ACT_ALLOC:    n_state = S_MUL;
                        ACT_REGISTER: n_state = S_REG;
                        ACT_FLUSH: begin
                            n_count = '0;
                            n_state = S_OUT;
                        end
                        default:      n_state = S_OUT;
                    endcase
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_block_size) * PROD_W'(w_q);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_seg > SEG_W'(r_prod[PROD_W-1:16])) begin
                    n_res_id    = r_bid;
                    n_res_size  = r_seg;
                    n_res_fresh = 1'b1;
                    n_state     = S_OUT;
                end else if (r_count == '0) begin
                    n_state = S_NEW;
                end else begin
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_rd_addr = r_idx + IDX_W'(1);
                if (w_fit.fits) begin
                    w_wr_en    = 1'b1;
                    w_wr_addr  = r_idx;
                    w_wr_data  = '{blk_id:   w_rd_data.blk_id,
                                   used:     w_fit.sum[BS_W-1:0],
                                   capacity: w_rd_data.capacity};
                    n_res_id   = w_rd_data.blk_id;
                    n_res_off  = w_fit.offset[OFF_W-1:0];
                    n_res_size = r_seg;
                    n_state    = S_OUT;
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_count) begin
                    n_state = S_NEW;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_NEW: begin
                n_res_id    = r_bid;
                n_res_size  = r_seg;
                n_res_fresh = 1'b1;
                if (r_count < CNT_MAX) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_res_status = ST_UNTRACKED;
                end
                n_state = S_OUT;
            end
            S_REG: begin
                w_wr_data = '{blk_id: r_bid, used: r_used, capacity: r_block_size};
                if (r_count < CNT_MAX) begin
                    w_wr_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_res_status = ST_DROPPED;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_res_size, r_res_off, r_res_id};
                    n_out_user  = {r_res_status, r_res_fresh};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_block_size <= BS_W'(262144);
            r_thr_q16    <= THR_W'(52429);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr) begin
                case (i_paddr)
                    REG_BLOCK_SIZE: r_block_size <= i_pwdata[BS_W-1:0];
                    REG_THRESHOLD:  r_thr_q16    <= i_pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg        <= n_seg;
        r_bid        <= n_bid;
        r_used       <= n_used;
        r_prod       <= n_prod;
        r_res_id     <= n_res_id;
        r_res_off    <= n_res_off;
        r_res_size   <= n_res_size;
        r_res_fresh  <= n_res_fresh;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_user   <= n_out_user;
    end

    `PFA_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_MAX)
    `PFA_ASSERT_NXT(a_busy_after_accept, w_s_accept, !o_s_tready)
    `PFA_ASSERT_IMP(a_fresh_at_zero, r_out_valid && r_out_user[0], r_out_data[55:32] == '0)
    `PFA_ASSERT_NXT(a_count_step, 1'b1, (r_count == '0) || (r_count - $past(r_count) <= CNT_W'(1)))
    `PFA_ASSERT_IMP(a_scan_in_table, r_state == S_SCAN, CNT_W'(r_idx) < r_count)

endmodule

// ----- sim/tb_partial_block_first_fit_allocator.sv -----
// Self-checking testbench for the partial block first-fit allocator.
module tb_partial_block_first_fit_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import pfa_pkg::*;

    localparam logic [2:0] REG_BLOCK_SIZE     = 3'd0;
    localparam logic [2:0] REG_FILL_THRESHOLD = 3'd4;
    localparam int         RANDOM_PER_PHASE   = 175;
    localparam int         NUM_PHASES         = 8;
    localparam logic [24:0] MAX_USED          = 25'h1000000;

    typedef struct packed {
        logic [31:0] res_id;
        logic [23:0] offset;
        logic [31:0] size;
        logic        fresh;
        t_status     status;
    } placement_t;

    class placement_tracker;
        logic [24:0] blk_bytes;
        logic [16:0] fill_q16;
        logic [31:0] slot_id   [MAX_PARTIAL_BLOCKS];
        logic [24:0] slot_used [MAX_PARTIAL_BLOCKS];
        logic [24:0] slot_cap  [MAX_PARTIAL_BLOCKS];
        int unsigned slot_count;
        placement_t  pending_placements[$];
        int          errors;

        function new();
            blk_bytes  = 25'd262144;
            fill_q16   = 17'd52429;
            slot_count = 0;
            errors     = 0;
        endfunction

        function logic [31:0] dedicated_limit();
            logic [16:0] q;
            logic [41:0] prod;
            q    = (fill_q16 > 17'd65536) ? 17'd65536 : fill_q16;
            prod = {17'd0, blk_bytes} * {25'd0, q};
            return {6'd0, prod[41:16]};
        endfunction

        function void add_slot(logic [31:0] id, logic [24:0] used);
            slot_id[slot_count]   = id;
            slot_used[slot_count] = used;
            slot_cap[slot_count]  = blk_bytes;
            slot_count++;
        endfunction

        function void note_request(t_action act, logic [31:0] seg, logic [31:0] bid,
                                   logic [24:0] used);
            placement_t p;
            logic [25:0] off;
            logic [32:0] sum;
            bit          placed;
            p        = '0;
            p.status = ST_OK;
            case (act)
                ACT_ALLOC: begin
                    p.size = seg;
                    if (seg > dedicated_limit()) begin
                        p.res_id = bid;
                        p.fresh  = 1'b1;
                    end else begin
                        placed = 1'b0;
                        for (int i = 0; i < slot_count && !placed; i++) begin
                            off = ({1'b0, slot_used[i]} + 26'd7) & ~26'd7;
                            sum = {7'd0, off} + {1'b0, seg};
                            if (sum <= {8'd0, slot_cap[i]}) begin
                                slot_used[i] = sum[24:0];
                                p.res_id     = slot_id[i];
                                p.offset     = off[23:0];
                                placed       = 1'b1;
                            end
                        end
                        if (!placed) begin
                            p.res_id = bid;
                            p.fresh  = 1'b1;
                            if (slot_count < MAX_PARTIAL_BLOCKS) begin
                                add_slot(bid, seg[24:0]);
                            end else begin
                                p.status = ST_UNTRACKED;
                            end
                        end
                    end
                end
                ACT_REGISTER: begin
                    if (slot_count < MAX_PARTIAL_BLOCKS) begin
                        add_slot(bid, used);
                    end else begin
                        p.status = ST_DROPPED;
                    end
                end
                ACT_FLUSH: slot_count = 0;
                default: ;
            endcase
            pending_placements.insert(pending_placements.size(), p);
        endfunction

        function void check_placement(placement_t got);
            placement_t want;
            if (pending_placements.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_placements.pop_front();
            if (got.res_id !== want.res_id) begin
                $error("result_block_id: expected %0h, actual %0h", want.res_id, got.res_id);
                errors++;
            end
            if (got.offset !== want.offset) begin
                $error("result_offset: expected %0h, actual %0h", want.offset, got.offset);
                errors++;
            end
            if (got.size !== want.size) begin
                $error("result_size: expected %0h, actual %0h", want.size, got.size);
                errors++;
            end
            if (got.fresh !== want.fresh) begin
                $error("used_fresh_id: expected %0b, actual %0b", want.fresh, got.fresh);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    logic [24:0] phase_bs [NUM_PHASES] = '{25'd262144, 25'd4096, 25'h1000000, 25'd4096,
                                           25'h1FFFFFF, 25'd4100, 25'h1000000, 25'd65536};
    logic [16:0] phase_q  [NUM_PHASES] = '{17'd52429, 17'd0, 17'd65536, 17'h1FFFF,
                                           17'd32768, 17'd1, 17'd65535, 17'd40000};

    placement_tracker tracker = new();

    partial_block_first_fit_allocator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : result_monitor
        placement_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.res_id = m_tdata[31:0];
            got.offset = m_tdata[55:32];
            got.size   = m_tdata[87:56];
            got.fresh  = m_tuser[0];
            got.status = t_status'(m_tuser[2:1]);
            tracker.check_placement(got);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] data;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== want) begin
            $error("prdata at %0h: expected %0h, actual %0h", addr, want, data);
            tracker.errors++;
        end
    endtask

    task automatic configure(input logic [24:0] bs, input logic [16:0] q);
        apb_write(REG_BLOCK_SIZE, {7'd0, bs});
        apb_write(REG_FILL_THRESHOLD, {15'd0, q});
        tracker.blk_bytes = bs;
        tracker.fill_q16  = q;
        apb_read_check(REG_BLOCK_SIZE, {7'd0, bs});
        apb_read_check(REG_FILL_THRESHOLD, {15'd0, q});
    endtask

    task automatic send_request(input t_action act, input logic [31:0] seg,
                                input logic [31:0] bid, input logic [24:0] used);
        @(negedge clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, used, bid, seg};
        s_tuser  <= act;
        do @(posedge clk); while (!s_tready);
        tracker.note_request(act, seg, bid, used);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending_placements.size() != 0) @(posedge clk);
    endtask

    task automatic random_request();
        t_action     act;
        logic [31:0] seg;
        logic [31:0] lim;
        logic [24:0] bs;
        logic [24:0] used_cap;
        logic [24:0] used;
        int          r;
        bs       = tracker.blk_bytes;
        lim      = tracker.dedicated_limit();
        used_cap = (bs > MAX_USED) ? MAX_USED : bs;
        r        = $urandom_range(0, 99);
        if (r < 68) act = ACT_ALLOC;
        else if (r < 86) act = ACT_REGISTER;
        else if (r < 95) act = ACT_FLUSH;
        else act = ACT_UNUSED;
        case ($urandom_range(0, 9))
            0: seg = $urandom_range(0, 16);
            1, 2, 3: seg = $urandom_range(0, bs / 8);
            4, 5: seg = $urandom_range(0, lim);
            6: seg = lim + $urandom_range(0, 2) - 1;
            7: seg = $urandom_range(0, bs);
            8: seg = $urandom;
            default: seg = lim;
        endcase
        case ($urandom_range(0, 4))
            0: used = '0;
            1: used = 25'($urandom_range(0, used_cap));
            2: used = used_cap - 25'($urandom_range(0, 8));
            3: used = 25'($urandom_range(0, MAX_USED));
            default: used = used_cap;
        endcase
        send_request(act, seg, $urandom, used);
    endtask

    initial begin
        logic [31:0] lim;
        logic [24:0] bs;
        logic [16:0] q;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_read_check(REG_BLOCK_SIZE, 32'd262144);
        apb_read_check(REG_FILL_THRESHOLD, 32'd52429);

        lim = tracker.dedicated_limit();
        send_request(ACT_ALLOC, lim, 32'h0000_0001, '0);
        send_request(ACT_ALLOC, lim + 1, 32'h0000_0002, MAX_USED);
        send_request(ACT_ALLOC, '0, '1, '0);
        send_request(ACT_ALLOC, '1, '1, MAX_USED);
        send_request(ACT_REGISTER, '0, '0, '0);
        send_request(ACT_REGISTER, '1, '1, MAX_USED);
        send_request(ACT_ALLOC, 32'd52424, 32'h0000_0003, '0);
        send_request(ACT_UNUSED, '1, '1, MAX_USED);
        send_request(ACT_FLUSH, '1, '1, MAX_USED);
        for (int i = 0; i < MAX_PARTIAL_BLOCKS; i++) begin
            send_request(ACT_ALLOC, lim, 32'h100 + i, '0);
        end
        send_request(ACT_ALLOC, lim, 32'h200, '0);
        send_request(ACT_REGISTER, '0, 32'h201, 25'd5);
        send_request(ACT_ALLOC, 32'd7, 32'h202, '0);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            bs = phase_bs[p];
            q  = phase_q[p];
            if (p == NUM_PHASES - 1) begin
                bs = 25'($urandom_range(4096, 16777216));
                q  = 17'($urandom_range(0, 65536));
            end
            configure(bs, q);
            send_request(ACT_FLUSH, $urandom, $urandom, '0);
            send_request(ACT_REGISTER, '0, $urandom, (bs > MAX_USED) ? MAX_USED : bs);
            send_request(ACT_ALLOC, '0, $urandom, '0);
            repeat (RANDOM_PER_PHASE) random_request();
            drain_results();
        end

        repeat (40) @(posedge clk);
        if (tracker.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- partial_block_first_fit_allocator.f -----
+incdir+sv
sv/pfa_pkg.sv
sv/pfa_table.sv
sv/pfa_fit.sv
sv/partial_block_first_fit_allocator.sv
sim/tb_partial_block_first_fit_allocator.sv
